/* design/cubic_bezier_sampler_core_macros.svh */
// Assertion macros shared by the cubic Bezier sampler RTL.
`ifndef CUBIC_BEZIER_SAMPLER_CORE_MACROS_SVH
`define CUBIC_BEZIER_SAMPLER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/cbs_pkg.sv */
// Shared types and constants of the cubic Bezier sampler.
`default_nettype none

package cbs_pkg;

    localparam int COORD_W = 16;  // input and output coordinate field width
    localparam int CP_W    = 18;  // control point width (anchor plus offset)
    localparam int WT_W    = 17;  // weight width, 16 fraction bits, up to 1.0
    localparam int WT_FRAC = 16;
    localparam int K_W     = 6;   // sample index width
    localparam int NPTS    = 4;   // control points per segment

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [CP_W-1:0]    cp_t;
    typedef logic [NPTS-1:0][CP_W-1:0] cp_vec_t;
    typedef logic [NPTS-1:0][WT_W-1:0] wt_vec_t;
    typedef logic [K_W-1:0]            kidx_t;

    // One sample issued by the sequencer into the evaluation pipeline.
    typedef struct packed {
        logic    valid;
        kidx_t   k;
        logic    last;
        cp_vec_t px;
        cp_vec_t py;
    } issue_t;

    // Sample leaving the weight stage.
    typedef struct packed {
        logic    valid;
        kidx_t   k;
        logic    last;
        cp_vec_t px;
        cp_vec_t py;
        wt_vec_t w;
    } wstage_t;

endpackage

`default_nettype wire

/* design/cbs_seg_if.sv */
// Channel that carries one Bezier segment (anchors and handle offsets).
`default_nettype none

interface cbs_seg_if;
    logic            valid;
    logic            ready;
    cbs_pkg::coord_t start_x;
    cbs_pkg::coord_t start_y;
    cbs_pkg::coord_t start_handle_dx;
    cbs_pkg::coord_t start_handle_dy;
    cbs_pkg::coord_t end_x;
    cbs_pkg::coord_t end_y;
    cbs_pkg::coord_t end_handle_dx;
    cbs_pkg::coord_t end_handle_dy;

    modport source (
        output valid, start_x, start_y, start_handle_dx, start_handle_dy,
               end_x, end_y, end_handle_dx, end_handle_dy,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_handle_dx, start_handle_dy,
               end_x, end_y, end_handle_dx, end_handle_dy,
        output ready
    );
endinterface

`default_nettype wire

/* design/cbs_pt_if.sv */
// Channel that carries one sampled curve point.
`default_nettype none

interface cbs_pt_if;
    logic            valid;
    logic            ready;
    cbs_pkg::coord_t point_x;
    cbs_pkg::coord_t point_y;
    cbs_pkg::kidx_t  sample_number;
    logic            last_sample;

    modport source (
        output valid, point_x, point_y, sample_number, last_sample,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, sample_number, last_sample,
        output ready
    );
endinterface

`default_nettype wire

/* design/cubic_bezier_sampler_core.sv */
// Top level of the cubic Bezier segment sampler.
`default_nettype none

// Each transfer on the segment channel is one 2D cubic Bezier segment given as
// two anchors and one handle offset per anchor; the block returns SEGMENTS+1
// points on the sample channel at t = k/SEGMENTS, k = 0..SEGMENTS, in order,
// with last_sample set on the final one. Coordinates are signed fixed point
// with 4 fraction bits; the Bernstein weights are exact-rounded constants
// with 16 fraction bits, and each point is rounded half up and saturated to
// the signed COORD_BITS range. The sample index sequencer issues one point per
// cycle while the pipeline advances, and the next segment is taken in the same
// cycle as the last sample of the current one is issued, so segments follow
// each other with no gap. Each point then passes a weight look-up stage, a
// multiply stage, two adder stages and a rounding and saturation stage whose
// register drives the sample channel; the segment itself is first registered
// in the sequencer. The whole pipeline holds while a valid point waits on the
// sample channel, and moves in every other cycle, so bubbles never stall the
// stream.
module cubic_bezier_sampler_core #(
    parameter int SEGMENTS   = 20,
    parameter int COORD_BITS = 16
) (
    input  wire       clk,
    input  wire       rst_n,
    cbs_seg_if.sink   segment,
    cbs_pt_if.source  sample
);

    `include "cubic_bezier_sampler_core_macros.svh"

    localparam int TAIL = 4;  // stages after the weight stage

    cbs_pkg::issue_t  issue;
    cbs_pkg::wstage_t wst;
    logic             adv;

    logic [TAIL-1:0]  valid_reg;
    cbs_pkg::kidx_t   k_reg    [TAIL];
    logic             last_reg [TAIL];

    // The pipeline advances unless the output register holds an unaccepted point.
    assign adv = !valid_reg[TAIL-1] || sample.ready;

    cbs_seq #(
        .SEGMENTS (SEGMENTS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .segment (segment),
        .adv     (adv),
        .issue   (issue)
    );

    cbs_wtab #(
        .SEGMENTS (SEGMENTS)
    ) u_wtab (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .issue (issue),
        .stage (wst)
    );

    cbs_axis #(
        .COORD_BITS (COORD_BITS)
    ) u_axis_x (
        .clk   (clk),
        .adv   (adv),
        .p     (wst.px),
        .w     (wst.w),
        .point (sample.point_x)
    );

    cbs_axis #(
        .COORD_BITS (COORD_BITS)
    ) u_axis_y (
        .clk   (clk),
        .adv   (adv),
        .p     (wst.py),
        .w     (wst.w),
        .point (sample.point_y)
    );

    // Valid bits and sample tags travel alongside the arithmetic stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[TAIL-2:0], wst.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_reg[0]    <= wst.k;
            last_reg[0] <= wst.last;
            for (int i = 1; i < TAIL; i++)
            begin
                k_reg[i]    <= k_reg[i-1];
                last_reg[i] <= last_reg[i-1];
            end
        end
    end

    assign sample.valid         = valid_reg[TAIL-1];
    assign sample.sample_number = k_reg[TAIL-1];
    assign sample.last_sample   = last_reg[TAIL-1];

    // The final sample of a segment carries the last index.
    `CBS_ASSERT_NOW(a_last_index, clk, rst_n,
        sample.valid && sample.last_sample,
        sample.sample_number == cbs_pkg::K_W'(SEGMENTS),
        "last sample flag on a sample other than the final index")

    // A held issue keeps its sample index while the pipeline is stalled.
    `CBS_ASSERT_NEXT(a_issue_hold, clk, rst_n,
        issue.valid && !adv,
        issue.valid && $stable(issue.k),
        "sequencer moved on while the pipeline was stalled")

    // A new segment is only taken when idle or on the last sample of the current one.
    `CBS_ASSERT_NOW(a_take_on_last, clk, rst_n,
        segment.valid && segment.ready && issue.valid,
        adv && issue.last,
        "segment taken while the sequencer still had samples to issue")

endmodule

`default_nettype wire

/* design/cbs_seq.sv */
// Segment sequencer: builds the control points and walks the sample index.
`default_nettype none

module cbs_seq #(
    parameter int SEGMENTS = 20
) (
    input  wire               clk,
    input  wire               rst_n,
    cbs_seg_if.sink           segment,
    input  wire               adv,
    output cbs_pkg::issue_t   issue
);

    localparam cbs_pkg::kidx_t K_LAST = cbs_pkg::K_W'(SEGMENTS);

    logic             busy_reg, busy_next;
    cbs_pkg::kidx_t   k_reg, k_next;
    cbs_pkg::cp_vec_t px_reg, px_next;
    cbs_pkg::cp_vec_t py_reg, py_next;
    logic             last;
    logic             accept;

    function automatic cbs_pkg::cp_t ext(input cbs_pkg::coord_t v);
        return cbs_pkg::CP_W'(v);
    endfunction

    assign last          = busy_reg && (k_reg == K_LAST);
    assign segment.ready = !busy_reg || (adv && last);
    assign accept        = segment.valid && segment.ready;

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        if (busy_reg && adv)
        begin
            if (last)
            begin
                busy_next = 1'b0;
                k_next    = '0;
            end
            else
            begin
                k_next = k_reg + 1'b1;
            end
        end
        if (accept)
        begin
            busy_next  = 1'b1;
            k_next     = '0;
            // P0 = start, P1 = start + handle, P2 = end + handle, P3 = end.
            px_next[0] = ext(segment.start_x);
            py_next[0] = ext(segment.start_y);
            px_next[1] = ext(segment.start_x) + ext(segment.start_handle_dx);
            py_next[1] = ext(segment.start_y) + ext(segment.start_handle_dy);
            px_next[2] = ext(segment.end_x) + ext(segment.end_handle_dx);
            py_next[2] = ext(segment.end_y) + ext(segment.end_handle_dy);
            px_next[3] = ext(segment.end_x);
            py_next[3] = ext(segment.end_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
    end

    assign issue.valid = busy_reg;
    assign issue.k     = k_reg;
    assign issue.last  = last;
    assign issue.px    = px_reg;
    assign issue.py    = py_reg;

endmodule

`default_nettype wire

/* design/cbs_wtab.sv */
// Weight stage: looks up the four Bernstein weights for the sample index.
`default_nettype none

module cbs_wtab #(
    parameter int SEGMENTS = 20
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                adv,
    input  cbs_pkg::issue_t    issue,
    output cbs_pkg::wstage_t   stage
);

    localparam int     TAB_N   = 2 ** cbs_pkg::K_W;
    localparam longint SegCube = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;

    // round(c_i * (S-k)^(3-i) * k^i * 2^16 / S^3), half up; zero past the end.
    function automatic longint weight_of(input int i, input int k);
        longint num;
        num = (i == 1 || i == 2) ? 64'sd3 : 64'sd1;
        if (k > SEGMENTS)
            return 64'sd0;
        for (int j = 0; j < 3 - i; j++)
            num = num * (SEGMENTS - k);
        for (int j = 0; j < i; j++)
            num = num * k;
        return ((num <<< cbs_pkg::WT_FRAC) + SegCube / 2) / SegCube;
    endfunction

    cbs_pkg::wt_vec_t wt_tab [TAB_N];

    for (genvar gk = 0; gk < TAB_N; gk++)
    begin : g_row
        for (genvar gi = 0; gi < cbs_pkg::NPTS; gi++)
        begin : g_col
            assign wt_tab[gk][gi] = cbs_pkg::WT_W'(weight_of(gi, gk));
        end
    end

    logic             valid_reg;
    cbs_pkg::kidx_t   k_reg;
    logic             last_reg;
    cbs_pkg::cp_vec_t px_reg;
    cbs_pkg::cp_vec_t py_reg;
    cbs_pkg::wt_vec_t w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= issue.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_reg    <= issue.k;
            last_reg <= issue.last;
            px_reg   <= issue.px;
            py_reg   <= issue.py;
            w_reg    <= wt_tab[issue.k];
        end
    end

    assign stage.valid = valid_reg;
    assign stage.k     = k_reg;
    assign stage.last  = last_reg;
    assign stage.px    = px_reg;
    assign stage.py    = py_reg;
    assign stage.w     = w_reg;

endmodule

`default_nettype wire

/* design/cbs_axis.sv */
// One coordinate axis: weighted products, adder tree, rounding and saturation.
`default_nettype none

module cbs_axis #(
    parameter int COORD_BITS = 16
) (
    input  wire               clk,
    input  wire               adv,
    input  cbs_pkg::cp_vec_t  p,
    input  cbs_pkg::wt_vec_t  w,
    output cbs_pkg::coord_t   point
);

    localparam int PROD_W = cbs_pkg::WT_W + 1 + cbs_pkg::CP_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PAIR_W + 2;
    localparam int Q_W    = SUM_W - cbs_pkg::WT_FRAC;
    localparam int QX_W   = 34;
    localparam logic signed [QX_W-1:0] SAT_HI =
        QX_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [QX_W-1:0] SAT_LO = -SAT_HI - 1;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (cbs_pkg::WT_FRAC - 1);

    logic signed [PROD_W-1:0] prod_reg [cbs_pkg::NPTS];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [SUM_W-1:0]  sum_reg;
    cbs_pkg::coord_t          point_reg;
    logic signed [Q_W-1:0]    q;
    logic signed [QX_W-1:0]   qx;
    logic signed [QX_W-1:0]   qsat;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < cbs_pkg::NPTS; i++)
                prod_reg[i] <= PROD_W'($signed({1'b0, w[i]}) * $signed(p[i]));
            pair_reg[0] <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            pair_reg[1] <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
            sum_reg     <= SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]) + HALF;
            point_reg   <= cbs_pkg::COORD_W'(qsat);
        end
    end

    // Floor shift of the rounded sum, then clamp to the signed coordinate range.
    assign q  = sum_reg[SUM_W-1:cbs_pkg::WT_FRAC];
    assign qx = {{(QX_W - Q_W){q[Q_W-1]}}, q};

    always_comb
    begin
        if (qx > SAT_HI)
            qsat = SAT_HI;
        else if (qx < SAT_LO)
            qsat = SAT_LO;
        else
            qsat = qx;
    end

    assign point = point_reg;

endmodule

`default_nettype wire

/* tb/cbs_sample_checker.sv */
// Checker for the cubic Bezier sampler: predicts the curve points of each segment and compares.
`timescale 1ns / 100ps

module cbs_sample_checker #(
    parameter int SEGMENTS   = 20,
    parameter int COORD_BITS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    cbs_seg_if          segment,
    cbs_pt_if           sample,
    output int unsigned fail_count,
    output int unsigned points_pending,
    output int unsigned points_checked,
    output int unsigned saturated_points
);

    typedef struct {
        cbs_pkg::coord_t x;
        cbs_pkg::coord_t y;
        cbs_pkg::kidx_t  k;
        logic            last;
    } curve_point_t;

    curve_point_t expected_points[$];

    int unsigned fails     = 0;
    int unsigned pending_n = 0;
    int unsigned checked_n = 0;
    int unsigned clipped_n = 0;

    assign fail_count       = fails;
    assign points_pending   = pending_n;
    assign points_checked   = checked_n;
    assign saturated_points = clipped_n;

    // Bernstein weight of control point i at t = k/SEGMENTS, 16 fraction bits, rounded half up.
    function automatic longint unsigned bern_weight(input int i, input int k);
        longint unsigned s;
        longint unsigned s3;
        longint unsigned num;
        int j;
        s   = longint'(SEGMENTS);
        s3  = s * s * s;
        num = (i == 0 || i == 3) ? 1 : 3;
        for (j = 0; j < 3 - i; j++)
            num = num * (s - longint'(k));
        for (j = 0; j < i; j++)
            num = num * longint'(k);
        return ((num << cbs_pkg::WT_FRAC) + s3 / 2) / s3;
    endfunction

    // One coordinate of the curve: weighted sum, rounded half up to 4 fraction bits, saturated.
    function automatic cbs_pkg::coord_t curve_coord(input longint p0, input longint p1,
                                                    input longint p2, input longint p3,
                                                    input int k, output bit clipped);
        longint acc;
        longint q;
        longint hi;
        longint lo;
        acc = longint'(bern_weight(0, k)) * p0 + longint'(bern_weight(1, k)) * p1
            + longint'(bern_weight(2, k)) * p2 + longint'(bern_weight(3, k)) * p3;
        q  = (acc + (longint'(1) <<< (cbs_pkg::WT_FRAC - 1))) >>> cbs_pkg::WT_FRAC;
        hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        clipped = (q > hi) || (q < lo);
        if (q > hi)
            q = hi;
        else if (q < lo)
            q = lo;
        return q[cbs_pkg::COORD_W-1:0];
    endfunction

    always @(posedge clk)
    begin : watch
        curve_point_t want;
        longint px[4];
        longint py[4];
        bit clip_x;
        bit clip_y;
        int k;
        if (rst_n)
        begin
            // Points are checked before the segment of the same edge is predicted, so a point
            // with nothing waiting is always caught.
            if (sample.valid && sample.ready)
            begin
                checked_n++;
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected point k=%0d x=%0d y=%0d last=%0b", $time,
                             sample.sample_number, sample.point_x, sample.point_y,
                             sample.last_sample);
                    fails++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (sample.point_x !== want.x || sample.point_y !== want.y ||
                        sample.sample_number !== want.k || sample.last_sample !== want.last)
                    begin
                        $display({"%0t: point mismatch, expected x=%0d y=%0d k=%0d last=%0b,",
                                  " got x=%0d y=%0d k=%0d last=%0b"},
                                 $time, want.x, want.y, want.k, want.last, sample.point_x,
                                 sample.point_y, sample.sample_number, sample.last_sample);
                        fails++;
                    end
                end
            end
            if (segment.valid && segment.ready)
            begin
                px[0] = longint'(segment.start_x);
                py[0] = longint'(segment.start_y);
                px[1] = longint'(segment.start_x) + longint'(segment.start_handle_dx);
                py[1] = longint'(segment.start_y) + longint'(segment.start_handle_dy);
                px[2] = longint'(segment.end_x) + longint'(segment.end_handle_dx);
                py[2] = longint'(segment.end_y) + longint'(segment.end_handle_dy);
                px[3] = longint'(segment.end_x);
                py[3] = longint'(segment.end_y);
                for (k = 0; k <= SEGMENTS; k++)
                begin
                    want.x    = curve_coord(px[0], px[1], px[2], px[3], k, clip_x);
                    want.y    = curve_coord(py[0], py[1], py[2], py[3], k, clip_y);
                    want.k    = cbs_pkg::kidx_t'(k);
                    want.last = (k == SEGMENTS);
                    if (clip_x || clip_y)
                        clipped_n++;
                    expected_points.push_back(want);
                end
            end
            pending_n = expected_points.size();
        end
    end

endmodule

/* tb/tb_cubic_bezier_sampler_core.sv */
// Top of the cubic Bezier sampler testbench: clock, reset, segment stimulus and verdict.
`timescale 1ns / 100ps

// The segment side sends a directed set of corner cases followed by random segments whose
// anchors and handles are drawn from several value spans. Each segment must come back as
// SEGMENTS+1 points on the sample channel; the checker beside the block predicts every point
// and counts failures. Both channels are driven at the falling edge and sampled at the rising
// edge, so nothing depends on the order of events within a time step.
module tb_cubic_bezier_sampler_core;

    localparam int SEGMENTS        = 20;
    localparam int COORD_BITS      = 16;
    localparam int RANDOM_SEGMENTS = 360;
    // Cycles without any transfer before the run is declared hung. The slowest correct run
    // sees long receiver stalls and six register stages, so this is ample.
    localparam int QUIET_LIMIT     = 2000;
    // Cycles allowed after the last expected point, in case the block emits a stray one.
    localparam int DRAIN_CYCLES    = 16;

    // Value spans used to shape random anchors and handles.
    typedef enum int {
        SPAN_FULL,
        SPAN_SMALL,
        SPAN_EXTREME,
        SPAN_NEAR_ZERO
    } span_e;

    logic clk;
    logic rst_n;
    // While set, neither side idles: this gives one long stretch of back-to-back transfers.
    logic calm = 1'b0;

    int unsigned fail_count;
    int unsigned points_pending;
    int unsigned points_checked;
    int unsigned saturated_points;
    int unsigned quiet_cycles = 0;
    int unsigned directed_n   = 0;
    int unsigned random_n     = 0;

    cbs_seg_if segment ();
    cbs_pt_if  sample ();

    cubic_bezier_sampler_core #(
        .SEGMENTS   (SEGMENTS),
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .segment (segment),
        .sample  (sample)
    );

    cbs_sample_checker #(
        .SEGMENTS   (SEGMENTS),
        .COORD_BITS (COORD_BITS)
    ) i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .segment          (segment),
        .sample           (sample),
        .fail_count       (fail_count),
        .points_pending   (points_pending),
        .points_checked   (points_checked),
        .saturated_points (saturated_points)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sample side: ready drops in about a quarter of cycles, and now and then for a long
    // spell, about three tenths of the time in all, so that back-pressure lands on every stage.
    initial
    begin
        sample.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && !calm && $urandom_range(0, 199) < 1)
            begin
                sample.ready = 1'b0;
                repeat ($urandom_range(8, 24)) @(negedge clk);
            end
            else
            begin
                sample.ready = rst_n && (calm || $urandom_range(0, 99) >= 26);
            end
        end
    end

    // Watchdog: a run in which nothing moves for too long has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (segment.valid && segment.ready) || (sample.valid && sample.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d points still awaited", $time,
                     QUIET_LIMIT, points_pending);
            $display("FAIL cubic_bezier_sampler_core");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one segment and returns at the rising edge of its transfer. Valid stays high
    // until the next falling edge, where the following call either idles or presents the next
    // segment, so valid is never lowered and raised within one step.
    task automatic send_segment(input cbs_pkg::coord_t sx, input cbs_pkg::coord_t sy,
                                input cbs_pkg::coord_t shx, input cbs_pkg::coord_t shy,
                                input cbs_pkg::coord_t ex, input cbs_pkg::coord_t ey,
                                input cbs_pkg::coord_t ehx, input cbs_pkg::coord_t ehy);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            segment.valid = 1'b0;
            @(negedge clk);
        end
        segment.start_x         = sx;
        segment.start_y         = sy;
        segment.start_handle_dx = shx;
        segment.start_handle_dy = shy;
        segment.end_x           = ex;
        segment.end_y           = ey;
        segment.end_handle_dx   = ehx;
        segment.end_handle_dy   = ehy;
        segment.valid           = 1'b1;
        @(posedge clk);
        while (!segment.ready)
            @(posedge clk);
    endtask

    // Withdraws the segment offer and waits until every predicted point has been returned.
    task automatic wait_for_drain();
        @(negedge clk);
        segment.valid = 1'b0;
        while (points_pending != 0)
            @(negedge clk);
    endtask

    function automatic cbs_pkg::coord_t pick_coord(input span_e span);
        case (span)
            SPAN_SMALL:     return cbs_pkg::coord_t'($urandom_range(0, 4095) - 2048);
            SPAN_NEAR_ZERO: return cbs_pkg::coord_t'($urandom_range(0, 31) - 16);
            SPAN_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            default:        return cbs_pkg::coord_t'($urandom);
        endcase
    endfunction

    initial
    begin
        span_e anchor_span;
        span_e handle_span;
        int n;

        rst_n                   = 1'b0;
        segment.valid           = 1'b0;
        segment.start_x         = '0;
        segment.start_y         = '0;
        segment.start_handle_dx = '0;
        segment.start_handle_dy = '0;
        segment.end_x           = '0;
        segment.end_y           = '0;
        segment.end_handle_dx   = '0;
        segment.end_handle_dy   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed corner cases. A degenerate segment at the origin comes first.
        send_segment(0, 0, 0, 0, 0, 0, 0, 0);
        // Every field at its positive limit: the handle points overflow the field, and
        // interior points must saturate high.
        send_segment(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                     16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        // Every field at its negative limit, saturating low.
        send_segment(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        // All four control points equal at either limit, with zero handles: only the excess
        // of the rounded weights over one can push the curve outside the range.
        send_segment(16'sh7FFF, 16'sh8000, 0, 0, 16'sh7FFF, 16'sh8000, 0, 0);
        send_segment(16'sh8000, 16'sh7FFF, 0, 0, 16'sh8000, 16'sh7FFF, 0, 0);
        // A straight line across the whole range in both directions.
        send_segment(16'sh8000, 16'sh8000, 0, 0, 16'sh7FFF, 16'sh7FFF, 0, 0);
        send_segment(16'sh7FFF, 16'sh8000, 0, 0, 16'sh8000, 16'sh7FFF, 0, 0);
        // Handles that fling the curve outwards in opposite senses.
        send_segment(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                     16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
        send_segment(0, 0, 16'sh7FFF, 16'sh7FFF, 0, 0, 16'sh8000, 16'sh8000);
        // All ones and alternating bit patterns.
        send_segment(16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF,
                     16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF);
        send_segment(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
                     16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
        send_segment(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
                     16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
        // Values of a few fractional steps, where rounding of halves decides the result.
        send_segment(1, -1, 0, 0, 2, -3, 0, 0);
        send_segment(-8, 8, 1, -1, 8, -8, -1, 1);
        send_segment(3, 5, 7, -9, -11, 13, 15, -17);
        directed_n = 15;

        // Random segments. Part way through, the sender holds off until the pipeline is
        // empty, and later there is a long stretch with no idling on either side.
        for (n = 0; n < RANDOM_SEGMENTS; n++)
        begin
            if (n == 120)
                wait_for_drain();
            calm = (n >= 200 && n < 260);
            anchor_span = span_e'($urandom_range(0, 3));
            handle_span = span_e'($urandom_range(0, 3));
            send_segment(pick_coord(anchor_span), pick_coord(anchor_span),
                         pick_coord(handle_span), pick_coord(handle_span),
                         pick_coord(anchor_span), pick_coord(anchor_span),
                         pick_coord(handle_span), pick_coord(handle_span));
            random_n++;
        end
        calm = 1'b0;

        // All stimulus is in; wait for the last points and then a little longer for strays.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d directed and %0d random segments and checked %0d curve points.",
                 directed_n, random_n, points_checked);
        $display({"%0d points reached the saturation limits; one full drain and one",
                  " stall-free run were included."}, saturated_points);
        if (fail_count == 0)
            $display("PASS cubic_bezier_sampler_core");
        else
            $display("FAIL cubic_bezier_sampler_core");
        $finish;
    end

endmodule
